// File: design/nvs_pkg.sv
package nvs_pkg;

	// Input item operations.
	typedef enum logic [1:0] {
		OP_LOAD_Y = 2'd0,
		OP_LOAD_C = 2'd1,
		OP_EMIT   = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_SRC_WIDTH    = 3'd0;
	localparam logic [2:0] REG_SRC_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_DST_LEFT     = 3'd2;
	localparam logic [2:0] REG_DST_TOP      = 3'd3;
	localparam logic [2:0] REG_BOX_WIDTH    = 3'd4;
	localparam logic [2:0] REG_BOX_HEIGHT   = 3'd5;
	localparam logic [2:0] REG_FILL_VALUE   = 3'd6;
	localparam logic [2:0] REG_CHROMA_ORDER = 3'd7;

	// Field and datapath widths.
	localparam int CFG_W   = 13;
	localparam int COORD_W = 12;
	localparam int SRC_W   = 10;
	localparam int BOX_W   = 13;
	localparam int NUM_W   = 22;
	localparam int QUO_W   = 10;

	// BT.601 integer coefficients.
	localparam int C_Y    = 298;
	localparam int C_RV   = 409;
	localparam int C_GU   = 100;
	localparam int C_GV   = 208;
	localparam int C_BU   = 516;
	localparam int ROUND  = 128;
	localparam int Y_OFF  = 16;
	localparam int C_OFF  = 128;

	// Item information carried down the pipeline.
	typedef struct packed {
		logic                 vld;
		logic [1:0]           op;
		logic [COORD_W-1:0]   col;
		logic [COORD_W-1:0]   row;
		logic [7:0]           data;
		logic                 boxed;
	} side_t;

	// Control passed to the color converter.
	typedef struct packed {
		logic vld;
		logic boxed;
	} pix_ctl_t;

endpackage

// File: design/nv12_scale_to_rgb.sv
// Throughput: one item per cycle while the output is not stalled; the ten-stage
// quotient pipelines and the single-port luma and chroma memories each take one item
// a cycle. A stall on the output holds the whole pipeline, and the input stalls with it.
// Reset clears the pipeline and sets the registers to their defaults; the
// frame memories are not cleared and hold nothing defined until loaded.
module nv12_scale_to_rgb #(
	parameter int MAX_SRC_WIDTH  = 512,
	parameter int MAX_SRC_HEIGHT = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic [11:0]                 column,
	input  logic [11:0]                 row,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic                        in_box,
	input  logic                        wr_en,
	input  logic [2:0]                  wr_index,
	input  logic [nvs_pkg::CFG_W-1:0]   wr_data
);

	localparam int W       = MAX_SRC_WIDTH;
	localparam int H       = MAX_SRC_HEIGHT;
	localparam int CW      = (W + 1) / 2;
	localparam int CR      = H / 2;
	localparam int Y_DEPTH = W * H;
	localparam int C_DEPTH = CW * CR;
	localparam int YAW     = $clog2(Y_DEPTH);
	localparam int CAW     = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
	localparam int XW      = $clog2(W);
	localparam int YW      = $clog2(H);
	localparam int DIV_ST  = nvs_pkg::QUO_W;

	// Configuration registers.
	logic [9:0]  src_width_q, src_height_q;
	logic [11:0] dst_left_q, dst_top_q;
	logic [12:0] box_width_q, box_height_q;
	logic [7:0]  fill_q;
	logic        order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 10'd512;
			src_height_q <= 10'd512;
			dst_left_q   <= '0;
			dst_top_q    <= '0;
			box_width_q  <= 13'd512;
			box_height_q <= 13'd512;
			fill_q       <= '0;
			order_q      <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				nvs_pkg::REG_SRC_WIDTH:    src_width_q  <= wr_data[9:0];
				nvs_pkg::REG_SRC_HEIGHT:   src_height_q <= wr_data[9:0];
				nvs_pkg::REG_DST_LEFT:     dst_left_q   <= wr_data[11:0];
				nvs_pkg::REG_DST_TOP:      dst_top_q    <= wr_data[11:0];
				nvs_pkg::REG_BOX_WIDTH:    box_width_q  <= wr_data;
				nvs_pkg::REG_BOX_HEIGHT:   box_height_q <= wr_data;
				nvs_pkg::REG_FILL_VALUE:   fill_q       <= wr_data[7:0];
				nvs_pkg::REG_CHROMA_ORDER: order_q      <= wr_data[0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as one unless the output register is stalled.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: input transfer register.
	nvs_pkg::side_t side_s1, side_s2, side_s3;
	nvs_pkg::side_t side_s [DIV_ST];
	logic [11:0] dx_s2, dy_s2;
	logic [nvs_pkg::NUM_W-1:0] nx_s3, ny_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1.vld   <= in_valid;
			side_s1.op    <= opcode;
			side_s1.col   <= column;
			side_s1.row   <= row;
			side_s1.data  <= data_byte;
			side_s1.boxed <= 1'b0;
		end
	end

	// Stage 2: box test and offsets into the box.
	logic in_x, in_y;
	nvs_pkg::side_t side_b;
	always_comb begin
		in_x = (side_s1.col >= dst_left_q) &&
			({2'b00, side_s1.col} < ({2'b00, dst_left_q} + {1'b0, box_width_q}));
		in_y = (side_s1.row >= dst_top_q) &&
			({2'b00, side_s1.row} < ({2'b00, dst_top_q} + {1'b0, box_height_q}));
		side_b       = side_s1;
		side_b.boxed = in_x && in_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
		end else if (en) begin
			side_s2 <= side_b;
			side_s3 <= side_s2;
		end
	end

	// Stage 3: numerators offset times source size.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2 <= side_s1.col - dst_left_q;
			dy_s2 <= side_s1.row - dst_top_q;
			nx_s3 <= dx_s2 * src_width_q;
			ny_s3 <= dy_s2 * src_height_q;
		end
	end

	// Quotient pipelines and the matching item delay line.
	logic [nvs_pkg::QUO_W-1:0] qx, qy;

	nvs_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (nx_s3),
		.den (box_width_q),
		.quo (qx)
	);

	nvs_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (ny_s3),
		.den (box_height_q),
		.quo (qy)
	);

	for (genvar i = 0; i < DIV_ST; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[i] <= '0;
			end else if (en) begin
				if (i == 0) begin
					side_s[i] <= side_s3;
				end else begin
					side_s[i] <= side_s[i-1];
				end
			end
		end
	end

	// Clamp the mapped source position and form memory accesses.
	nvs_pkg::side_t side_m;
	logic [12:0] lim_x, lim_y, sx13, sy13;
	logic [XW-1:0] sx;
	logic [YW-1:0] sy;
	logic emit_m, y_we, c_we, ce_we, co_we, czero_m, ozero_m;
	logic [YAW-1:0] y_addr;
	logic [CAW-1:0] c_addr;

	assign side_m = side_s[DIV_ST-1];

	always_comb begin
		lim_x = (src_width_q == '0) ? 13'd1 : {3'b000, src_width_q};
		if (lim_x > 13'(W)) begin
			lim_x = 13'(W);
		end
		lim_y = (src_height_q == '0) ? 13'd1 : {3'b000, src_height_q};
		if (lim_y > 13'(H)) begin
			lim_y = 13'(H);
		end
		sx13 = (13'(qx) > lim_x - 13'd1) ? lim_x - 13'd1 : 13'(qx);
		sy13 = (13'(qy) > lim_y - 13'd1) ? lim_y - 13'd1 : 13'(qy);
		sx   = sx13[XW-1:0];
		sy   = sy13[YW-1:0];

		emit_m  = side_m.vld && (side_m.op == nvs_pkg::OP_EMIT);
		y_we    = side_m.vld && (side_m.op == nvs_pkg::OP_LOAD_Y) &&
			({1'b0, side_m.col} < 13'(W)) && ({1'b0, side_m.row} < 13'(H));
		c_we    = side_m.vld && (side_m.op == nvs_pkg::OP_LOAD_C) &&
			({1'b0, side_m.col} < 13'(W)) && ({1'b0, side_m.row} < 13'(CR));
		ce_we   = c_we && !side_m.col[0];
		co_we   = c_we && side_m.col[0];
		czero_m = (13'(sy13 >> 1) >= 13'(CR));
		ozero_m = ((sx13 | 13'd1) >= 13'(W));

		if (y_we) begin
			y_addr = YAW'(side_m.row) * YAW'(W) + YAW'(side_m.col);
		end else begin
			y_addr = YAW'(sy) * YAW'(W) + YAW'(sx);
		end
		if (c_we) begin
			c_addr = CAW'(side_m.row) * CAW'(CW) + CAW'(side_m.col >> 1);
		end else begin
			c_addr = CAW'(sy >> 1) * CAW'(CW) + CAW'(sx >> 1);
		end
	end

	// Frame memories: luma, and chroma split into even and odd byte banks.
	logic [7:0] y_rd, ce_rd, co_rd;

	nvs_ram #(.WIDTH(8), .DEPTH(Y_DEPTH)) u_luma (
		.clk   (clk),
		.en    (en),
		.we    (y_we),
		.addr  (y_addr),
		.wdata (side_m.data),
		.rdata (y_rd)
	);

	nvs_ram #(.WIDTH(8), .DEPTH(C_DEPTH)) u_chroma_even (
		.clk   (clk),
		.en    (en),
		.we    (ce_we),
		.addr  (c_addr),
		.wdata (side_m.data),
		.rdata (ce_rd)
	);

	nvs_ram #(.WIDTH(8), .DEPTH(C_DEPTH)) u_chroma_odd (
		.clk   (clk),
		.en    (en),
		.we    (co_we),
		.addr  (c_addr),
		.wdata (side_m.data),
		.rdata (co_rd)
	);

	// Memory output stage: control that travels with the read data.
	nvs_pkg::pix_ctl_t ctl_s14;
	logic czero_s14, ozero_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s14 <= '0;
		end else if (en) begin
			ctl_s14.vld   <= emit_m;
			ctl_s14.boxed <= side_m.boxed;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			czero_s14 <= czero_m;
			ozero_s14 <= ozero_m;
		end
	end

	// Chroma pair outside the store reads as zero; NV21 swaps the pair.
	logic [7:0] first, second, u_pix, v_pix;
	always_comb begin
		first  = czero_s14 ? 8'd0 : ce_rd;
		second = (czero_s14 || ozero_s14) ? 8'd0 : co_rd;
		u_pix  = order_q ? second : first;
		v_pix  = order_q ? first : second;
	end

	nvs_csc u_csc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl       (ctl_s14),
		.y         (y_rd),
		.u         (u_pix),
		.v         (v_pix),
		.fill      (fill_q),
		.out_valid (out_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.in_box    (in_box)
	);

	// A fill pixel carries the same byte on all channels.
	a_fill_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_box) |-> (red == green && green == blue))
		else $error("fill pixel channels differ");

	// A chroma load writes at most one bank.
	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ce_we, co_we}))
		else $error("both chroma banks written");

	// The input only stalls behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled without a pending result");

endmodule

// File: design/nvs_ram.sv
module nvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port with registered read; the read data holds while en is low.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

// File: design/nvs_div.sv
module nvs_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [nvs_pkg::NUM_W-1:0] num,
	input  logic [nvs_pkg::BOX_W-1:0] den,
	output logic [nvs_pkg::QUO_W-1:0] quo
);

	localparam int NW = nvs_pkg::NUM_W;
	localparam int QW = nvs_pkg::QUO_W;

	logic [NW-1:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar i = 0; i < QW; i++) begin : g_st
		logic [NW-1:0] r_prev;
		logic [QW-1:0] q_prev;
		logic [NW:0]   dsh;

		if (i == 0) begin : g_first
			assign r_prev = num;
			assign q_prev = '0;
		end else begin : g_next
			assign r_prev = rem_s[i-1];
			assign q_prev = quo_s[i-1];
		end

		assign dsh = (NW+1)'(den) << (QW - 1 - i);

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, r_prev} >= dsh) begin
					rem_s[i] <= r_prev - dsh[NW-1:0];
					quo_s[i] <= q_prev | (QW'(1) << (QW - 1 - i));
				end else begin
					rem_s[i] <= r_prev;
					quo_s[i] <= q_prev;
				end
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

// File: design/nvs_csc.sv
module nvs_csc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  nvs_pkg::pix_ctl_t ctl,
	input  logic [7:0]        y,
	input  logic [7:0]        u,
	input  logic [7:0]        v,
	input  logic [7:0]        fill,
	output logic              out_valid,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              in_box
);

	nvs_pkg::pix_ctl_t ctl_s1;
	logic signed [19:0] pc_s1, pe_r_s1, pd_g_s1, pe_g_s1, pd_b_s1;
	logic signed [19:0] cs, ds, es;
	logic signed [19:0] sr, sg, sb;

	// Floor by 256 and saturate to a byte.
	function automatic logic [7:0] sat8(input logic signed [19:0] val);
		logic signed [19:0] t;
		t = val >>> 8;
		if (t < 0) begin
			return 8'd0;
		end else if (t > 20'sd255) begin
			return 8'd255;
		end
		return t[7:0];
	endfunction

	// Offsets: Y-16 floored at zero, chroma centered on 128.
	always_comb begin
		if (y >= 8'(nvs_pkg::Y_OFF)) begin
			cs = $signed({12'd0, y - 8'(nvs_pkg::Y_OFF)});
		end else begin
			cs = '0;
		end
		ds = $signed({12'd0, u}) - 20'(nvs_pkg::C_OFF);
		es = $signed({12'd0, v}) - 20'(nvs_pkg::C_OFF);
	end

	// First stage: coefficient products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1   <= cs * $signed(20'(nvs_pkg::C_Y));
			pe_r_s1 <= es * $signed(20'(nvs_pkg::C_RV));
			pd_g_s1 <= ds * $signed(20'(nvs_pkg::C_GU));
			pe_g_s1 <= es * $signed(20'(nvs_pkg::C_GV));
			pd_b_s1 <= ds * $signed(20'(nvs_pkg::C_BU));
		end
	end

	// Second stage: sums with rounding, then saturation or the fill value.
	always_comb begin
		sr = pc_s1 + pe_r_s1 + 20'(nvs_pkg::ROUND);
		sg = pc_s1 - pd_g_s1 - pe_g_s1 + 20'(nvs_pkg::ROUND);
		sb = pc_s1 + pd_b_s1 + 20'(nvs_pkg::ROUND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_box <= ctl_s1.boxed;
			if (ctl_s1.boxed) begin
				red   <= sat8(sr);
				green <= sat8(sg);
				blue  <= sat8(sb);
			end else begin
				red   <= fill;
				green <= fill;
				blue  <= fill;
			end
		end
	end

endmodule
